>>> design/tid_pkg.sv
// Package for the tape image deframer: parse phase codes, byte kind codes,
// file type codes, the result record type and the file counter limit.
// No dependencies.
package tid_pkg;

  // Width of the file index and the counter limit it implies (at most 255)
  localparam int FILE_INDEX_BITS = 8;
  localparam int FILE_CAP_INT    = (FILE_INDEX_BITS >= 8) ? 255 : ((1 << FILE_INDEX_BITS) - 1);
  localparam logic [7:0] FILE_CAP = 8'(FILE_CAP_INT);

  // Parse phases
  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_BETWEEN    = 3'd1;
  localparam logic [2:0] PH_AFTER_MARK = 3'd2;
  localparam logic [2:0] PH_NAME       = 3'd3;
  localparam logic [2:0] PH_TYPE       = 3'd4;
  localparam logic [2:0] PH_HEADER     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD    = 3'd6;
  localparam logic [2:0] PH_ERROR      = 3'd7;

  // File types
  localparam logic [1:0] TYPE_A = 2'd0;
  localparam logic [1:0] TYPE_B = 2'd1;
  localparam logic [1:0] TYPE_M = 2'd2;

  // Byte kinds
  localparam logic [1:0] KIND_SKIP  = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_BODY  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Framing bytes
  localparam logic [7:0] BYTE_MARK  = 8'hA5;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_A     = 8'h41;
  localparam logic [7:0] BYTE_B     = 8'h42;
  localparam logic [7:0] BYTE_M     = 8'h4D;

  // Header layout and trailer sizes
  localparam logic [2:0] LEN_POS_A    = 3'd3;
  localparam logic [2:0] LEN_POS_BM   = 3'd1;
  localparam logic [2:0] HDR_LAST_POS = 3'd5;
  localparam logic [3:0] TRAILER_A    = 4'd12;
  localparam logic [3:0] TRAILER_B    = 4'd3;
  localparam logic [3:0] TRAILER_M    = 4'd7;

  // One tagged output byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] byte_kind;
    logic       body_end;
    logic [7:0] file_number;
    logic       stream_ok;
  } result_t;

endpackage

>>> design/tape_image_deframer.sv
// Tape image deframer top level: byte parser with output register and skid.
// Depends on tid_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one raw image byte per
//   transfer with last_byte marking the final byte of the image. Output
//   channel (out_valid / out_stall) carries one tagged byte per input byte:
//   the byte itself, its kind (skipped, name, body, error), a mark on the
//   last body byte of each file, the file index and, on the last byte, a
//   clean-end flag.
//   Each result is registered in the output register, or in the skid register.
//   Throughput is one byte per cycle while in_stall is low; the parser state
//   updates at each accepted byte, so consecutive bytes follow back to back.
//   When the receiver stalls, the result holds in the output register and
//   one more byte is taken into a skid register; in_stall then rises until
//   the output drains.
//   Reset (rst, synchronous) empties both registers and returns the parser
//   to image start with the file count cleared. The same happens inside the
//   parser after the byte flagged last_byte.
module tape_image_deframer
  import tid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic [1:0] byte_kind,
  output logic       body_end,
  output logic [7:0] file_number,
  output logic       stream_ok
);

  // Parser state
  logic [2:0]  phase, phase_next;
  logic [2:0]  header_position, header_position_next;
  logic [1:0]  file_type, file_type_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [7:0]  file_count, file_count_next;

  // Output register and skid stage
  logic    out_full, skid_full;
  result_t out_reg, skid_reg;
  result_t res;

  logic accept;
  assign in_stall = skid_full;
  assign accept   = in_valid && !skid_full;

  // Per-byte parse
  always_comb begin
    logic       bad;
    logic       opened;
    logic [1:0] kind;
    logic       end_mark;
    logic       ok;
    logic [2:0] lo_pos;
    logic [3:0] trailer;
    logic [2:0] pos_inc;

    phase_next           = phase;
    header_position_next = header_position;
    file_type_next       = file_type;
    length_low_byte_next = length_low_byte;
    bytes_left_next      = bytes_left;
    file_count_next      = file_count;
    bad      = 1'b0;
    opened   = 1'b0;
    kind     = KIND_SKIP;
    end_mark = 1'b0;
    ok       = 1'b0;
    lo_pos   = (file_type == TYPE_A) ? LEN_POS_A : LEN_POS_BM;
    trailer  = (file_type == TYPE_A) ? TRAILER_A :
               ((file_type == TYPE_B) ? TRAILER_B : TRAILER_M);
    pos_inc  = header_position + 3'd1;

    case (phase)
      PH_START, PH_BETWEEN, PH_AFTER_MARK: begin
        if (phase == PH_BETWEEN && byte_value == 8'd0) begin
          opened = 1'b1;
        end else if (phase != PH_AFTER_MARK && byte_value == BYTE_MARK) begin
          phase_next = PH_AFTER_MARK;
          opened     = 1'b1;
        end else if (byte_value == BYTE_QUOTE) begin
          phase_next = PH_NAME;
          opened     = 1'b1;
        end else if (byte_value == BYTE_A) begin
          phase_next           = PH_HEADER;
          file_type_next       = TYPE_A;
          header_position_next = 3'd1;
          length_low_byte_next = 8'd0;
          bytes_left_next      = 17'd0;
          kind                 = KIND_BODY;
          opened               = 1'b1;
        end
        bad = !opened;
      end
      PH_NAME: begin
        if (byte_value == 8'd0) begin
          bad = 1'b1;
        end else if (byte_value == BYTE_QUOTE) begin
          phase_next = PH_TYPE;
        end else begin
          kind = KIND_NAME;
        end
      end
      PH_TYPE: begin
        kind                 = KIND_BODY;
        header_position_next = 3'd1;
        length_low_byte_next = 8'd0;
        bytes_left_next      = 17'd0;
        phase_next           = PH_HEADER;
        if (byte_value == BYTE_A) begin
          file_type_next = TYPE_A;
        end else if (byte_value == BYTE_B) begin
          file_type_next = TYPE_B;
        end else if (byte_value == BYTE_M) begin
          file_type_next = TYPE_M;
        end else begin
          bad = 1'b1;
        end
      end
      PH_HEADER: begin
        kind = KIND_BODY;
        if (header_position == lo_pos) begin
          length_low_byte_next = byte_value;
          header_position_next = pos_inc;
        end else if (header_position == lo_pos + 3'd1) begin
          bytes_left_next      = {1'b0, byte_value, length_low_byte} + {13'd0, trailer};
          header_position_next = 3'd0;
          phase_next           = PH_PAYLOAD;
        end else begin
          header_position_next = (pos_inc > HDR_LAST_POS) ? lo_pos : pos_inc;
        end
      end
      PH_PAYLOAD: begin
        kind = KIND_BODY;
        if (bytes_left <= 17'd1) begin
          bytes_left_next = 17'd0;
          end_mark        = 1'b1;
          phase_next      = PH_BETWEEN;
          if (file_count < FILE_CAP) begin
            file_count_next = file_count + 8'd1;
          end
        end else begin
          bytes_left_next = bytes_left - 17'd1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // Sticky error
    if (bad) begin
      phase_next = PH_ERROR;
      kind       = KIND_ERROR;
      end_mark   = 1'b0;
    end

    // End of image: judge, then return to image start
    if (last_byte) begin
      if (!bad && phase_next == PH_BETWEEN) begin
        ok = 1'b1;
      end else begin
        kind     = KIND_ERROR;
        end_mark = 1'b0;
      end
      phase_next           = PH_START;
      header_position_next = 3'd0;
      file_type_next       = TYPE_A;
      length_low_byte_next = 8'd0;
      bytes_left_next      = 17'd0;
      file_count_next      = 8'd0;
    end

    res.data_byte   = byte_value;
    res.byte_kind   = kind;
    res.body_end    = end_mark;
    res.file_number = file_count;
    res.stream_ok   = ok;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      header_position <= 3'd0;
      file_type       <= TYPE_A;
      length_low_byte <= 8'd0;
      bytes_left      <= 17'd0;
      file_count      <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      file_type       <= file_type_next;
      length_low_byte <= length_low_byte_next;
      bytes_left      <= bytes_left_next;
      file_count      <= file_count_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || !out_stall) begin
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full <= accept;
      end
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (!out_full || !out_stall) begin
      if (skid_full) begin
        out_reg <= skid_reg;
      end else if (accept) begin
        out_reg <= res;
      end
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign out_valid   = out_full;
  assign data_byte   = out_reg.data_byte;
  assign byte_kind   = out_reg.byte_kind;
  assign body_end    = out_reg.body_end;
  assign file_number = out_reg.file_number;
  assign stream_ok   = out_reg.stream_ok;

  // Skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid register full while output register empty");

  // End of file mark only on body bytes
  a_end_is_body: assert property (@(posedge clk) disable iff (rst)
    (out_valid && body_end) |-> (byte_kind == KIND_BODY))
    else $error("body_end on a non-body byte");

  // Clean end never tagged as error
  a_ok_not_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_ok) |-> (byte_kind != KIND_ERROR))
    else $error("stream_ok on an error byte");

  // Error is sticky until the last byte
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_ERROR && !last_byte) |=> (phase == PH_ERROR))
    else $error("left error phase before end of image");

  // Last byte returns the parser to image start
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (phase == PH_START && file_count == 8'd0))
    else $error("parser not back at image start after last byte");

endmodule

>>> sim/tb_tape_image_deframer.sv
`timescale 1ns / 100ps
// Testbench for tape_image_deframer: directed and random tape images go in one
// byte per transfer, and every tagged output byte is checked against a parser
// model kept here. Depends on tid_pkg and the tape_image_deframer RTL.
module tb_tape_image_deframer
  import tid_pkg::*;
();

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } tape_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] byte_value = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic [1:0] byte_kind;
  logic       body_end;
  logic [7:0] file_number;
  logic       stream_ok;

  tape_image_deframer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_kind   (byte_kind),
    .body_end    (body_end),
    .file_number (file_number),
    .stream_ok   (stream_ok)
  );

  always #6 clk = ~clk;

  // Bytes waiting to be sent, tagged bytes waiting to come out
  tape_byte_t  tape_q[$];
  result_t     tagged_q[$];
  logic [7:0]  image_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          queued_items = 0;
  int          images = 0;
  int          mismatches = 0;
  int          checked = 0;
  int          closed_files = 0;
  int          error_bytes = 0;
  int          clean_ends = 0;

  // Parser model state
  logic [2:0]  prs_phase;
  logic [2:0]  prs_hdr_pos;
  logic [1:0]  prs_type;
  logic [7:0]  prs_len_lo;
  logic [16:0] prs_left;
  logic [7:0]  prs_files;

  function automatic void parser_clear();
    prs_phase   = PH_START;
    prs_hdr_pos = 3'd0;
    prs_type    = TYPE_A;
    prs_len_lo  = 8'd0;
    prs_left    = 17'd0;
    prs_files   = 8'd0;
  endfunction

  function automatic void start_body(input logic [1:0] ft);
    prs_type    = ft;
    prs_hdr_pos = 3'd1;
    prs_len_lo  = 8'd0;
    prs_left    = 17'd0;
    prs_phase   = PH_HEADER;
  endfunction

  // Append one byte to the image under construction
  function automatic void put_image_byte(input logic [7:0] b);
    image_q.insert(image_q.size(), b);
  endfunction

  // Tag one image byte and advance the parser model
  function automatic result_t parse_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic       bad;
    logic [2:0] lo_pos;
    logic [3:0] trailer;
    r.data_byte   = b;
    r.byte_kind   = KIND_SKIP;
    r.body_end    = 1'b0;
    r.file_number = prs_files;
    r.stream_ok   = 1'b0;
    bad = 1'b0;
    case (prs_phase)
      PH_START, PH_BETWEEN, PH_AFTER_MARK: begin
        if (prs_phase == PH_BETWEEN && b == 8'h00) r.byte_kind = KIND_SKIP;
        else if (prs_phase != PH_AFTER_MARK && b == BYTE_MARK) prs_phase = PH_AFTER_MARK;
        else if (b == BYTE_QUOTE) prs_phase = PH_NAME;
        else if (b == BYTE_A) begin
          start_body(TYPE_A);
          r.byte_kind = KIND_BODY;
        end else bad = 1'b1;
      end
      PH_NAME: begin
        if (b == 8'h00) bad = 1'b1;
        else if (b == BYTE_QUOTE) prs_phase = PH_TYPE;
        else r.byte_kind = KIND_NAME;
      end
      PH_TYPE: begin
        r.byte_kind = KIND_BODY;
        if (b == BYTE_A) start_body(TYPE_A);
        else if (b == BYTE_B) start_body(TYPE_B);
        else if (b == BYTE_M) start_body(TYPE_M);
        else bad = 1'b1;
      end
      PH_HEADER: begin
        r.byte_kind = KIND_BODY;
        lo_pos  = (prs_type == TYPE_A) ? LEN_POS_A : LEN_POS_BM;
        trailer = (prs_type == TYPE_A) ? TRAILER_A :
                  (prs_type == TYPE_B) ? TRAILER_B : TRAILER_M;
        if (prs_hdr_pos == lo_pos) begin
          prs_len_lo  = b;
          prs_hdr_pos = prs_hdr_pos + 3'd1;
        end else if (prs_hdr_pos == lo_pos + 3'd1) begin
          prs_left    = 17'({b, prs_len_lo}) + 17'(trailer);
          prs_hdr_pos = 3'd0;
          prs_phase   = PH_PAYLOAD;
        end else begin
          prs_hdr_pos = prs_hdr_pos + 3'd1;
          if (prs_hdr_pos > HDR_LAST_POS) prs_hdr_pos = lo_pos;
        end
      end
      PH_PAYLOAD: begin
        r.byte_kind = KIND_BODY;
        if (prs_left <= 17'd1) begin
          prs_left   = 17'd0;
          r.body_end = 1'b1;
          prs_phase  = PH_BETWEEN;
          if (prs_files < FILE_CAP) prs_files = prs_files + 8'd1;
        end else begin
          prs_left = prs_left - 17'd1;
        end
      end
      default: bad = 1'b1;
    endcase

    // Errors are sticky until the end of the image
    if (bad) begin
      prs_phase   = PH_ERROR;
      r.byte_kind = KIND_ERROR;
      r.body_end  = 1'b0;
    end

    // Last byte: clean only between files; then back to image start
    if (last) begin
      if (!bad && prs_phase == PH_BETWEEN) begin
        r.stream_ok = 1'b1;
      end else begin
        r.byte_kind = KIND_ERROR;
        r.body_end  = 1'b0;
      end
      parser_clear();
    end
    return r;
  endfunction

  initial parser_clear();

  // Input driver: take the next byte once the current one has transferred
  always @(posedge clk) begin : drive
    tape_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        tagged_q.insert(tagged_q.size(), parse_byte(byte_value, last_byte));
      if (!in_valid || !in_stall) begin
        if (tape_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = tape_q.pop_front();
          in_valid   <= 1'b1;
          byte_value <= nxt.value;
          last_byte  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output monitor: compare each transfer with the oldest pending tag
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tagged_q.size() == 0) begin
          $display("%0t: unexpected output transfer, data %0h kind %0d", $time,
                   data_byte, byte_kind);
          mismatches++;
        end else begin
          want = tagged_q.pop_front();
          check_field("data_byte", want.data_byte, data_byte);
          check_field("byte_kind", 8'(want.byte_kind), 8'(byte_kind));
          check_field("body_end", 8'(want.body_end), 8'(body_end));
          check_field("file_number", want.file_number, file_number);
          check_field("stream_ok", 8'(want.stream_ok), 8'(stream_ok));
          checked++;
          if (want.body_end) closed_files++;
          if (want.byte_kind == KIND_ERROR) error_bytes++;
          if (want.stream_ok) clean_ends++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Queue the first cut bytes of the built image, last flag on the final one
  task automatic send_image(input int cut);
    tape_byte_t tb;
    for (int i = 0; i < cut; i++) begin
      tb.value = image_q[i];
      tb.last  = (i == cut - 1);
      tape_q.insert(tape_q.size(), tb);
    end
    queued_items += cut;
    images++;
    image_q.delete();
  endtask

  // Append one well-formed file with random content
  task automatic add_file(input logic [1:0] ft, input int len, input bit mark,
                          input bit named);
    logic [7:0] c;
    if (mark) put_image_byte(BYTE_MARK);
    if (named || ft != TYPE_A) begin
      put_image_byte(BYTE_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(1, 255));
        put_image_byte(c == BYTE_QUOTE ? 8'h2E : c);
      end
      put_image_byte(BYTE_QUOTE);
    end
    put_image_byte(ft == TYPE_A ? BYTE_A : (ft == TYPE_B ? BYTE_B : BYTE_M));
    if (ft == TYPE_A) repeat (2) put_image_byte(8'($urandom_range(0, 255)));
    put_image_byte(len[7:0]);
    put_image_byte(len[15:8]);
    repeat (len + (ft == TYPE_A ? int'(TRAILER_A) : ft == TYPE_B ? int'(TRAILER_B) :
                   int'(TRAILER_M)))
      put_image_byte(8'($urandom_range(0, 255)));
  endtask

  // One random image: mostly well formed, some cut short, corrupted or noise
  task automatic random_image();
    int mode;
    int pos;
    int len;
    repeat ($urandom_range(1, 4)) begin
      len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(25, 400)) :
                                           int'($urandom_range(0, 24));
      add_file(2'($urandom_range(0, 2)), len, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) put_image_byte(8'h00);
    end
    mode = int'($urandom_range(0, 99));
    if (mode < 60) begin
      send_image(image_q.size());
    end else if (mode < 75) begin
      send_image(int'($urandom_range(1, image_q.size())));
    end else if (mode < 90) begin
      pos = int'($urandom_range(0, image_q.size() - 1));
      image_q[pos] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      send_image(image_q.size());
    end else begin
      image_q.delete();
      repeat ($urandom_range(1, 12)) put_image_byte(8'($urandom_range(0, 255)));
      send_image(image_q.size());
    end
  endtask

  task automatic run_random(input int n);
    int start;
    start = queued_items;
    while (queued_items - start < n) random_image();
  endtask

  task automatic drain();
    while (tape_q.size() != 0 || in_valid || tagged_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    send_idle_pct = 28;
    recv_idle_pct = 74;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Zero as first byte, then the error holds to the end
    image_q = '{8'h00, 8'hFF, BYTE_A};
    send_image(3);
    // Bad opener on a one-byte image
    image_q = '{8'hFF};
    send_image(1);
    // Type letter B right after the mark byte
    image_q = '{BYTE_MARK, BYTE_B};
    send_image(2);
    // Zero inside a name
    image_q = '{BYTE_QUOTE, BYTE_A, 8'h00, BYTE_QUOTE};
    send_image(4);
    // Bad type letter after a name
    image_q = '{BYTE_QUOTE, BYTE_QUOTE, 8'h58};
    send_image(3);
    // Marked, named type B file with zero length, ending on a zero
    image_q = '{BYTE_MARK, BYTE_QUOTE, 8'h7F, BYTE_QUOTE, BYTE_B, 8'h00, 8'h00,
                8'hFF, 8'h80, 8'h01, 8'h00};
    send_image(11);

    run_random(330);
    drain();
    send_idle_pct = 74;
    recv_idle_pct = 28;
    run_random(330);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(330);

    drain();
    repeat (20) @(negedge clk);
    $display("Ran %0d images, %0d bytes checked: %0d files closed, %0d error tags,",
             images, checked, closed_files, error_bytes);
    $display("%0d clean image ends; %0d mismatches.", clean_ends, mismatches);
    if (mismatches == 0) begin
      $display("[tape_image_deframer] OK");
    end else begin
      $display("[tape_image_deframer] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("Timeout with %0d bytes unsent and %0d tags pending", tape_q.size(),
             tagged_q.size());
    $display("[tape_image_deframer] ERROR");
    $finish;
  end

endmodule
